// File: rtl/prc_pkg.sv
package prc_pkg;

    localparam int VOLT_BITS_DEFAULT = 18;
    localparam int FIELD_VOLT_BITS   = 18;
    localparam int RATIO_BITS        = 9;
    localparam int MS_BITS           = 16;
    localparam int CFG_INDEX_BITS    = 3;
    localparam int CFG_DATA_BITS     = 16;

    localparam logic [MS_BITS-1:0] MS_MAX = {MS_BITS{1'b1}};

    // item kinds
    localparam logic CMD_TICK   = 1'b0;
    localparam logic CMD_SAMPLE = 1'b1;

    // configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_USE_RELAY      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_USE_PRECHARGE  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RATIO          = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_PRE_TIMEOUT_MS = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_OVERLAP_MS     = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RETRY_MS       = 3'd5;

    // configuration reset values
    localparam logic                  RST_USE_RELAY      = 1'b1;
    localparam logic                  RST_USE_PRECHARGE  = 1'b1;
    localparam logic [RATIO_BITS-1:0] RST_RATIO          = 9'd230;
    localparam logic [MS_BITS-1:0]    RST_PRE_TIMEOUT_MS = 16'd300;
    localparam logic [MS_BITS-1:0]    RST_OVERLAP_MS     = 16'd200;
    localparam logic [MS_BITS-1:0]    RST_RETRY_MS       = 16'd5000;

    typedef enum logic [2:0] {
        ST_OFF         = 3'd0,
        ST_PRECHARGING = 3'd1,
        ST_PRECHARGED  = 3'd2,
        ST_ENABLED     = 3'd3,
        ST_TIMEOUT     = 3'd4
    } ctrl_state_t;

    typedef struct packed {
        logic                       cmd;
        logic                       enable_desired;
        logic [FIELD_VOLT_BITS-1:0] bus_millivolts;
        logic [FIELD_VOLT_BITS-1:0] battery_millivolts;
    } item_t;

    typedef struct packed {
        logic       main_relay_on;
        logic       precharge_relay_on;
        logic       load_enabled;
        logic       precharge_active;
        logic       precharge_error;
        logic [2:0] controller_state;
    } result_t;

    typedef struct packed {
        logic                  use_relay;
        logic                  use_precharge;
        logic [RATIO_BITS-1:0] precharge_ratio;
        logic [MS_BITS-1:0]    precharge_timeout_ms;
        logic [MS_BITS-1:0]    relay_overlap_ms;
        logic [MS_BITS-1:0]    retry_interval_ms;
    } cfg_t;

endpackage

// File: rtl/prc_cfg_regs.sv
module prc_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [prc_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output prc_pkg::cfg_t                       cfg
);

    prc_pkg::cfg_t cfg_reg;
    prc_pkg::cfg_t cfg_next;

    // writes never wait
    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                prc_pkg::CFG_USE_RELAY:      cfg_next.use_relay = cfg_data[0];
                prc_pkg::CFG_USE_PRECHARGE:  cfg_next.use_precharge = cfg_data[0];
                prc_pkg::CFG_RATIO:
                    cfg_next.precharge_ratio = cfg_data[prc_pkg::RATIO_BITS-1:0];
                prc_pkg::CFG_PRE_TIMEOUT_MS: cfg_next.precharge_timeout_ms = cfg_data;
                prc_pkg::CFG_OVERLAP_MS:     cfg_next.relay_overlap_ms = cfg_data;
                prc_pkg::CFG_RETRY_MS:       cfg_next.retry_interval_ms = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.use_relay            <= prc_pkg::RST_USE_RELAY;
            cfg_reg.use_precharge        <= prc_pkg::RST_USE_PRECHARGE;
            cfg_reg.precharge_ratio      <= prc_pkg::RST_RATIO;
            cfg_reg.precharge_timeout_ms <= prc_pkg::RST_PRE_TIMEOUT_MS;
            cfg_reg.relay_overlap_ms     <= prc_pkg::RST_OVERLAP_MS;
            cfg_reg.retry_interval_ms    <= prc_pkg::RST_RETRY_MS;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: rtl/prc_seq.sv
module prc_seq #(
    parameter int VOLT_BITS = prc_pkg::VOLT_BITS_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step_en,
    input  prc_pkg::item_t    item,
    input  prc_pkg::cfg_t     cfg,
    output prc_pkg::result_t  result_next
);

    localparam int PROD_BITS = VOLT_BITS + prc_pkg::RATIO_BITS;

    prc_pkg::ctrl_state_t state_reg;
    prc_pkg::ctrl_state_t state_next;
    logic                 desired_seen_reg;
    logic                 desired_seen_next;
    logic [prc_pkg::MS_BITS-1:0] ms_reg;
    logic [prc_pkg::MS_BITS-1:0] ms_next;

    prc_pkg::ctrl_state_t cur;
    prc_pkg::ctrl_state_t enable_target;
    logic [prc_pkg::MS_BITS-1:0] ms_inc;
    logic [VOLT_BITS-1:0] bus_v;
    logic [VOLT_BITS-1:0] bat_v;
    logic [PROD_BITS-1:0] bus_scaled;
    logic [PROD_BITS-1:0] bat_scaled;
    logic                 bus_ge;
    logic                 bus_le;

    // voltages are taken to their low VOLT_BITS bits
    assign bus_v      = VOLT_BITS'(item.bus_millivolts);
    assign bat_v      = VOLT_BITS'(item.battery_millivolts);
    assign bus_scaled = PROD_BITS'({bus_v, 8'd0});
    assign bat_scaled = PROD_BITS'(bat_v) * PROD_BITS'(cfg.precharge_ratio);
    assign bus_ge     = (bus_scaled >= bat_scaled);
    assign bus_le     = (bus_scaled <= bat_scaled);

    assign ms_inc = (ms_reg == prc_pkg::MS_MAX) ? ms_reg : ms_reg + 1'b1;
    assign enable_target = cfg.use_precharge ? prc_pkg::ST_PRECHARGING
                                             : prc_pkg::ST_ENABLED;

    always_comb
    begin
        case (state_reg)
            prc_pkg::ST_PRECHARGING: cur = prc_pkg::ST_PRECHARGING;
            prc_pkg::ST_PRECHARGED:  cur = prc_pkg::ST_PRECHARGED;
            prc_pkg::ST_ENABLED:     cur = prc_pkg::ST_ENABLED;
            prc_pkg::ST_TIMEOUT:     cur = prc_pkg::ST_TIMEOUT;
            default:                 cur = prc_pkg::ST_OFF;
        endcase

        state_next        = cur;
        desired_seen_next = desired_seen_reg;
        ms_next           = ms_reg;

        if (item.cmd == prc_pkg::CMD_SAMPLE)
        begin
            if (item.enable_desired != desired_seen_reg)
            begin
                state_next = (item.enable_desired && cfg.use_relay) ? enable_target
                                                                    : prc_pkg::ST_OFF;
                desired_seen_next = item.enable_desired;
            end
            if (state_next == prc_pkg::ST_PRECHARGING && bus_ge)
                state_next = prc_pkg::ST_PRECHARGED;
            if (state_next == prc_pkg::ST_ENABLED && cfg.use_precharge && bus_le)
                state_next = prc_pkg::ST_TIMEOUT;
        end
        else
        begin
            ms_next = ms_inc;
            case (cur)
                prc_pkg::ST_PRECHARGING:
                    if (ms_inc >= cfg.precharge_timeout_ms)
                        state_next = prc_pkg::ST_TIMEOUT;
                prc_pkg::ST_PRECHARGED:
                    if (ms_inc >= cfg.relay_overlap_ms)
                        state_next = prc_pkg::ST_ENABLED;
                prc_pkg::ST_TIMEOUT:
                    if (ms_inc >= cfg.retry_interval_ms)
                        state_next = enable_target;
                default: ;
            endcase
        end

        // timer restarts on entry to the timed states
        if (state_next != cur &&
            (state_next == prc_pkg::ST_PRECHARGING ||
             state_next == prc_pkg::ST_PRECHARGED ||
             state_next == prc_pkg::ST_TIMEOUT))
            ms_next = '0;

        result_next = '0;
        result_next.controller_state = state_next;
        case (state_next)
            prc_pkg::ST_PRECHARGING:
            begin
                result_next.precharge_relay_on = 1'b1;
                result_next.precharge_active   = 1'b1;
            end
            prc_pkg::ST_PRECHARGED:
            begin
                result_next.main_relay_on      = 1'b1;
                result_next.load_enabled       = 1'b1;
                result_next.precharge_relay_on = 1'b1;
                result_next.precharge_active   = 1'b1;
            end
            prc_pkg::ST_ENABLED:
            begin
                result_next.main_relay_on = 1'b1;
                result_next.load_enabled  = 1'b1;
            end
            prc_pkg::ST_TIMEOUT:
                result_next.precharge_error = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= prc_pkg::ST_OFF;
            desired_seen_reg <= 1'b0;
            ms_reg           <= '0;
        end
        else if (step_en)
        begin
            state_reg        <= state_next;
            desired_seen_reg <= desired_seen_next;
            ms_reg           <= ms_next;
        end
    end

endmodule

// File: rtl/precharge_relay_controller_unit.sv
// A request accepted is held in the input register; its result is then registered in the
// result register and offered. The step waits while the result side is stalled.
// Throughput: one request per cycle; the sequencer step (voltage ratio multiply,
// compare and state update) is combinational between the input and result registers.
// A stalled result holds off new requests only when both stages are full.
// Reset: state off, enable not seen, timer zero, registers at their defaults, no result.
module precharge_relay_controller_unit #(
    parameter int VOLT_BITS = prc_pkg::VOLT_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    output logic                                item_stall,
    input  prc_pkg::item_t                      item,
    output logic                                result_valid,
    input  logic                                result_stall,
    output prc_pkg::result_t                    result,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [prc_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [prc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    prc_pkg::cfg_t    cfg;
    prc_pkg::item_t   item_reg;
    logic             in_valid_reg;
    logic             in_valid_next;
    prc_pkg::result_t result_reg;
    prc_pkg::result_t result_next;
    logic             result_valid_reg;
    logic             result_valid_next;
    logic             res_free;
    logic             step_en;
    logic             item_take;

    prc_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    prc_seq #(
        .VOLT_BITS (VOLT_BITS)
    ) u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .step_en     (step_en),
        .item        (item_reg),
        .cfg         (cfg),
        .result_next (result_next)
    );

    assign res_free   = !result_valid_reg || !result_stall;
    assign step_en    = in_valid_reg && res_free;
    assign item_stall = in_valid_reg && !res_free;
    assign item_take  = item_valid && !item_stall;

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (item_take)
            in_valid_next = 1'b1;
        else if (step_en)
            in_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (step_en)
            result_valid_next = 1'b1;
        else if (!result_stall)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg     <= in_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_take)
            item_reg <= item;
        if (step_en)
            result_reg <= result_next;
    end

endmodule

// File: rtl/prc_checker.sv
module prc_checker (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  logic                                item_stall,
    input  logic                                result_valid,
    input  logic                                result_stall,
    input  prc_pkg::result_t                    result
);

    // requests back up only behind a held result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("request stalled while result side free");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(result)))
        else $error("stalled result dropped or changed");

    // a request taken with room ahead passes the input and result registers and yields a result
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall && !result_valid) |=> ##1 result_valid)
        else $error("result missing after request");

    a_drive_match: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.main_relay_on == result.load_enabled &&
                          result.precharge_relay_on == result.precharge_active &&
                          !(result.precharge_error &&
                            (result.main_relay_on || result.precharge_relay_on))))
        else $error("relay drives and status flags disagree");

    a_state_code: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.controller_state == prc_pkg::ST_OFF ||
                          result.controller_state == prc_pkg::ST_PRECHARGING ||
                          result.controller_state == prc_pkg::ST_PRECHARGED ||
                          result.controller_state == prc_pkg::ST_ENABLED ||
                          result.controller_state == prc_pkg::ST_TIMEOUT) &&
                         (result.precharge_error ==
                          (result.controller_state == prc_pkg::ST_TIMEOUT)))
        else $error("state code and error flag disagree");

endmodule

bind precharge_relay_controller_unit prc_checker u_prc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
);
